FILE: rtl/stg_pkg.sv
// Shared types and constants for the space-time grid neighbour expander.
// Used by stg_cons_scan and space_time_grid_neighbor_expander.
`timescale 1ns / 1ps
`default_nettype none

package stg_pkg;

  localparam int MAX_DIM_DEF  = 64;
  localparam int MAX_CONS_DEF = 64;
  localparam int NUM_MOVES    = 5;
  // candidate coordinates carry one bit above the 6-bit field for the +1 moves
  localparam int COORD_W      = 7;

  localparam logic [1:0] MODE_OBST   = 2'd0;
  localparam logic [1:0] MODE_CONS   = 2'd1;
  localparam logic [1:0] MODE_EXPAND = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_AGENT  = 2'd2;
  localparam logic [1:0] REG_COUNT  = 2'd3;

  localparam logic [2:0] MOVE_WAIT = 3'd0;
  localparam logic [2:0] MOVE_XP   = 3'd1;
  localparam logic [2:0] MOVE_XM   = 3'd2;
  localparam logic [2:0] MOVE_YP   = 3'd3;
  localparam logic [2:0] MOVE_YM   = 3'd4;

  localparam logic [6:0] GRID_W_RST = 7'd64;
  localparam logic [6:0] GRID_H_RST = 7'd64;
  localparam logic [7:0] AGENT_RST  = 8'd0;
  localparam logic [6:0] COUNT_RST  = 7'd0;

  localparam logic [15:0] COST_MAX = 16'hFFFF;
  localparam logic [13:0] TIME_MAX = 14'h3FFF;

  // one constraint table row, 48 bits
  typedef struct packed {
    logic        kind;
    logic [8:0]  agent;
    logic [5:0]  vx;
    logic [5:0]  vy;
    logic [5:0]  ex;
    logic [5:0]  ey;
    logic [13:0] ctime;
  } cons_entry_t;

  typedef struct packed {
    logic clear;
    logic rd_en;
  } scan_ctl_t;

  // node under expansion, as the constraint matcher sees it
  typedef struct packed {
    logic [5:0]  px;
    logic [5:0]  py;
    logic [13:0] t_now;
    logic [14:0] t_next;
    logic [7:0]  agent;
  } node_key_t;

endpackage

`default_nettype wire

FILE: rtl/stg_obst_map.sv
// Obstacle bitmap: single-port-write, registered-read memory with a
// clearing sweep after reset. Depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none

module stg_obst_map #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr,
  input  wire logic                                 wr_bit,
  input  wire logic                                 rd_en,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   rd_addr,
  output logic                                      rd_bit,
  output logic                                      busy
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // sweep has the write port until it is done
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/stg_cons_scan.sv
// Constraint table memory and per-entry matcher that folds hits for all
// five moves into a mask. Depends on stg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stg_cons_scan #(
  parameter int MAX_CONSTRAINTS = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      wr_en,
  input  wire logic [((MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1)-1:0] wr_addr,
  input  wire stg_pkg::cons_entry_t                      wr_entry,
  input  wire stg_pkg::scan_ctl_t                        ctl,
  input  wire logic [((MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1)-1:0] rd_addr,
  input  wire stg_pkg::node_key_t                        key,
  input  wire logic [stg_pkg::NUM_MOVES-1:0][stg_pkg::COORD_W-1:0] cand_x,
  input  wire logic [stg_pkg::NUM_MOVES-1:0][stg_pkg::COORD_W-1:0] cand_y,
  output logic [stg_pkg::NUM_MOVES-1:0]                  hit_mask
);

  stg_pkg::cons_entry_t                 mem [MAX_CONSTRAINTS];
  stg_pkg::cons_entry_t                 rd_entry;
  logic                                 rd_vld;
  logic                                 binds;
  logic [stg_pkg::NUM_MOVES-1:0]        match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (ctl.rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ctl.rd_en;
    end
  end

  // agent sign bit set: binds every agent
  assign binds = rd_entry.agent[8] || (rd_entry.agent == {1'b0, key.agent});

  always_comb begin
    for (int m = 0; m < stg_pkg::NUM_MOVES; m++) begin
      match[m] = rd_vld && binds && (
        (!rd_entry.kind &&
         ({1'b0, rd_entry.ctime} == key.t_next) &&
         ({1'b0, rd_entry.vx} == cand_x[m]) &&
         ({1'b0, rd_entry.vy} == cand_y[m])) ||
        (rd_entry.kind &&
         (rd_entry.ctime == key.t_now) &&
         (rd_entry.vx == key.px) && (rd_entry.vy == key.py) &&
         ({1'b0, rd_entry.ex} == cand_x[m]) &&
         ({1'b0, rd_entry.ey} == cand_y[m])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_mask <= '0;
    end else if (ctl.clear) begin
      hit_mask <= '0;
    end else begin
      hit_mask <= hit_mask | match;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/space_time_grid_neighbor_expander.sv
// Expand: an item reads its four move cells from the obstacle map, then scans N entries of
//   the constraint table one entry per cycle, N being min(constraint_count, MAX_CONSTRAINTS);
//   results then go out one per cycle while out_ready allows, up to five.
// Items are taken only while idle: load items one per cycle, expand items one at a time.
// Reset: control and configuration registers take their defaults; the obstacle map's
//   MAX_DIM*MAX_DIM cells (4096 by default) are swept clear while in_ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module space_time_grid_neighbor_expander #(
  parameter int MAX_DIM         = stg_pkg::MAX_DIM_DEF,
  parameter int MAX_CONSTRAINTS = stg_pkg::MAX_CONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [5:0]         pos_x,
  input  wire logic [5:0]         pos_y,
  input  wire logic [15:0]        g_cost,
  input  wire logic [13:0]        time_step,
  input  wire logic [15:0]        node_id,
  input  wire logic               obstacle_bit,
  input  wire logic [5:0]         constraint_slot,
  input  wire logic               constraint_kind,
  input  wire logic signed [8:0]  constraint_agent,
  input  wire logic [5:0]         edge_to_x,
  input  wire logic [5:0]         edge_to_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [5:0]              neighbor_x,
  output logic [5:0]              neighbor_y,
  output logic [15:0]             out_g_cost,
  output logic [13:0]             out_time,
  output logic [15:0]             parent_node,
  output logic [2:0]              move_kind,
  output logic                    is_last,
  output logic                    none_found
);

  localparam int NM      = stg_pkg::NUM_MOVES;
  localparam int CW      = stg_pkg::COORD_W;
  localparam int OBST_AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int CIW     = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
  localparam int SCW     = $clog2(MAX_CONSTRAINTS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_OBST  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_PREP  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  // configuration
  logic [6:0] grid_width;
  logic [6:0] grid_height;
  logic [7:0] agent_number;
  logic [6:0] constraint_count;

  // sequencer and per-node state
  logic [2:0]              state;
  logic [2:0]              mv;
  logic [SCW-1:0]          idx;
  logic [SCW-1:0]          scan_len;
  stg_pkg::node_key_t      key;
  logic [NM-1:0][CW-1:0]   cand_x;
  logic [NM-1:0][CW-1:0]   cand_y;
  logic [NM-1:0]           inb;
  logic [NM-1:0]           blocked;
  logic [NM-1:0]           rem;
  logic [15:0]             gn;
  logic [13:0]             tn;
  logic [15:0]             parent;
  logic                    obst_pend;
  logic [2:0]              obst_mv;

  // candidate build from the input ports
  logic [NM-1:0][CW-1:0]   cand_x_d;
  logic [NM-1:0][CW-1:0]   cand_y_d;
  logic [NM-1:0]           inb_d;
  logic [CW-1:0]           cx;
  logic [CW-1:0]           cy;
  logic                    ok;
  int                      w_lim;
  int                      h_lim;

  logic                    accept;
  logic                    clr_busy;
  logic                    obst_wr_en;
  logic [OBST_AW-1:0]      obst_wr_addr;
  logic                    obst_rd_en;
  logic [OBST_AW-1:0]      obst_rd_addr;
  logic                    obst_rd_bit;
  logic                    cons_wr_en;
  stg_pkg::cons_entry_t    cons_entry;
  stg_pkg::scan_ctl_t      scan_ctl;
  logic [NM-1:0]           hit_mask;

  logic [NM-1:0]           pick_oh;
  logic [2:0]              pick_mv;
  logic                    found;
  logic [NM-1:0]           rem_left;
  logic                    slot_free;

  assign in_ready  = (state == ST_IDLE) && !clr_busy;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= stg_pkg::GRID_W_RST;
      grid_height      <= stg_pkg::GRID_H_RST;
      agent_number     <= stg_pkg::AGENT_RST;
      constraint_count <= stg_pkg::COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        stg_pkg::REG_WIDTH:  grid_width       <= cfg_data[6:0];
        stg_pkg::REG_HEIGHT: grid_height      <= cfg_data[6:0];
        stg_pkg::REG_AGENT:  agent_number     <= cfg_data;
        stg_pkg::REG_COUNT:  constraint_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_lim    = (int'(grid_width) > MAX_DIM) ? MAX_DIM : int'(grid_width);
    h_lim    = (int'(grid_height) > MAX_DIM) ? MAX_DIM : int'(grid_height);
    cand_x_d = '0;
    cand_y_d = '0;
    inb_d    = '0;
    cx       = '0;
    cy       = '0;
    ok       = 1'b0;
    for (int m = 0; m < NM; m++) begin
      cx = {1'b0, pos_x};
      cy = {1'b0, pos_y};
      ok = 1'b1;
      case (3'(m))
        stg_pkg::MOVE_XP: cx = cx + CW'(1);
        stg_pkg::MOVE_XM: begin
          ok = (pos_x != 6'd0);
          cx = cx - CW'(1);
        end
        stg_pkg::MOVE_YP: cy = cy + CW'(1);
        stg_pkg::MOVE_YM: begin
          ok = (pos_y != 6'd0);
          cy = cy - CW'(1);
        end
        default: ;
      endcase
      cand_x_d[m] = cx;
      cand_y_d[m] = cy;
      inb_d[m]    = ok && (int'(cx) < w_lim) && (int'(cy) < h_lim);
    end
  end

  // load items write straight into the memories
  assign obst_wr_en   = accept && (mode == stg_pkg::MODE_OBST) &&
                        (int'(pos_x) < MAX_DIM) && (int'(pos_y) < MAX_DIM);
  assign obst_wr_addr = OBST_AW'(int'(pos_y) * MAX_DIM + int'(pos_x));
  assign cons_wr_en   = accept && (mode == stg_pkg::MODE_CONS) &&
                        (int'(constraint_slot) < MAX_CONSTRAINTS);

  always_comb begin
    cons_entry.kind  = constraint_kind;
    cons_entry.agent = $unsigned(constraint_agent);
    cons_entry.vx    = pos_x;
    cons_entry.vy    = pos_y;
    cons_entry.ex    = edge_to_x;
    cons_entry.ey    = edge_to_y;
    cons_entry.ctime = time_step;
  end

  assign obst_rd_en     = (state == ST_OBST);
  assign obst_rd_addr   = OBST_AW'(int'(cand_y[mv]) * MAX_DIM + int'(cand_x[mv]));
  assign scan_ctl.clear = accept && (mode == stg_pkg::MODE_EXPAND);
  assign scan_ctl.rd_en = (state == ST_SCAN);

  stg_obst_map #(
    .MAX_DIM (MAX_DIM)
  ) u_obst (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (obst_wr_en),
    .wr_addr (obst_wr_addr),
    .wr_bit  (obstacle_bit),
    .rd_en   (obst_rd_en),
    .rd_addr (obst_rd_addr),
    .rd_bit  (obst_rd_bit),
    .busy    (clr_busy)
  );

  stg_cons_scan #(
    .MAX_CONSTRAINTS (MAX_CONSTRAINTS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cons_wr_en),
    .wr_addr  (CIW'(constraint_slot)),
    .wr_entry (cons_entry),
    .ctl      (scan_ctl),
    .rd_addr  (idx[CIW-1:0]),
    .key      (key),
    .cand_x   (cand_x),
    .cand_y   (cand_y),
    .hit_mask (hit_mask)
  );

  // lowest surviving move goes out first
  always_comb begin
    pick_oh = '0;
    pick_mv = stg_pkg::MOVE_WAIT;
    found   = 1'b0;
    for (int m = 0; m < NM; m++) begin
      if (rem[m] && !found) begin
        found      = 1'b1;
        pick_oh[m] = 1'b1;
        pick_mv    = 3'(m);
      end
    end
  end

  assign rem_left = rem & ~pick_oh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mv        <= stg_pkg::MOVE_XP;
      idx       <= '0;
      obst_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      obst_pend <= obst_rd_en;
      if ((state == ST_EMIT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (mode == stg_pkg::MODE_EXPAND)) begin
            state <= ST_OBST;
            mv    <= stg_pkg::MOVE_XP;
          end
        end
        ST_OBST: begin
          mv  <= mv + 3'd1;
          idx <= '0;
          if (mv == stg_pkg::MOVE_YM) begin
            state <= (scan_len != '0) ? ST_SCAN : ST_DRAIN;
          end
        end
        ST_SCAN: begin
          idx <= idx + SCW'(1);
          if (idx == scan_len - SCW'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_PREP;
        ST_PREP:  state <= ST_EMIT;
        ST_EMIT: begin
          if (slot_free) begin
            if ((rem == '0) || (rem_left == '0)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-node registers and result payload
  always_ff @(posedge clk) begin
    if (accept && (mode == stg_pkg::MODE_EXPAND)) begin
      key.px     <= pos_x;
      key.py     <= pos_y;
      key.t_now  <= time_step;
      key.t_next <= {1'b0, time_step} + 15'd1;
      key.agent  <= agent_number;
      cand_x     <= cand_x_d;
      cand_y     <= cand_y_d;
      inb        <= inb_d;
      blocked    <= '0;
      gn         <= (g_cost == stg_pkg::COST_MAX) ? g_cost : g_cost + 16'd1;
      tn         <= (time_step == stg_pkg::TIME_MAX) ? time_step : time_step + 14'd1;
      parent     <= node_id;
      scan_len   <= (int'(constraint_count) > MAX_CONSTRAINTS) ?
                    SCW'(MAX_CONSTRAINTS) : SCW'(constraint_count);
    end else if (obst_pend) begin
      blocked[obst_mv] <= obst_rd_bit & inb[obst_mv];
    end
    obst_mv <= mv;
    if (state == ST_PREP) begin
      rem <= inb & ~blocked & ~hit_mask;
    end else if ((state == ST_EMIT) && slot_free) begin
      rem <= rem_left;
    end
    if ((state == ST_EMIT) && slot_free) begin
      parent_node <= parent;
      if (rem == '0) begin
        neighbor_x <= '0;
        neighbor_y <= '0;
        out_g_cost <= '0;
        out_time   <= '0;
        move_kind  <= stg_pkg::MOVE_WAIT;
        is_last    <= 1'b1;
        none_found <= 1'b1;
      end else begin
        neighbor_x <= cand_x[pick_mv][5:0];
        neighbor_y <= cand_y[pick_mv][5:0];
        out_g_cost <= gn;
        out_time   <= tn;
        move_kind  <= pick_mv;
        is_last    <= (rem_left == '0);
        none_found <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_found |-> is_last)
    else $error("none result not marked last");

  a_empty_emit_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && slot_free && (rem == '0) |=>
      (state == ST_IDLE) && out_valid && none_found)
    else $error("empty expansion did not give a single none result");

  a_expand_starts_clean: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == stg_pkg::MODE_EXPAND) |=>
      (state == ST_OBST) && (hit_mask == '0) && (blocked == '0))
    else $error("expansion started with stale hit or obstacle state");
`endif

endmodule

`default_nettype wire
